// ===== hdl/kslp_pkg.sv =====
// Shared types and constants for the key short/long press detector.
// No dependencies; imported by every module of the block.
package kslp_pkg;

    localparam int KEY_LEVEL_BITS = 6;
    localparam int KEY_INDEX_W    = 3;
    localparam int EVENT_W        = 2;
    localparam int COUNT_W        = 8;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 8;
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 8;
    localparam int DEF_NUM_KEYS   = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;
    localparam logic [COUNT_W-1:0] LONG_TICKS_RESET = 8'd80;
    localparam logic [COUNT_W-1:0] SHORT_MIN_RESET  = 8'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_MIN  = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [COUNT_W-1:0] long_ticks;
        logic [COUNT_W-1:0] short_min;
    } t_cfg;

    // Per-item control broadcast to every key cell
    typedef struct packed {
        logic step;
        logic scan;
    } t_key_ctl;

endpackage

// ===== hdl/kslp_cfg.sv =====
// Configuration register file: long press threshold and short press minimum.
// Depends on kslp_pkg.
module kslp_cfg
    import kslp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ticks <= LONG_TICKS_RESET;
            r_cfg.short_min  <= SHORT_MIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LONG_TICKS: r_cfg.long_ticks <= i_cfg_data;
                CFG_SHORT_MIN:  r_cfg.short_min  <= i_cfg_data;
            endcase
        end
    end

endmodule

// ===== hdl/kslp_key_cell.sv =====
// State of one key: held tick count, long press lock and latched event.
// Depends on kslp_pkg.
module kslp_key_cell
    import kslp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_key_ctl i_ctl,
    input  t_cfg     i_cfg,
    input  logic     i_pressed,
    input  logic     i_read_clr,
    output t_event   o_event,
    output logic     o_next_pending
);

    logic [COUNT_W-1:0] r_count, n_count, count_inc;
    logic               r_lock, n_lock;
    t_event             r_event, n_event;

    assign count_inc = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    always_comb begin
        n_count = r_count;
        n_lock  = r_lock;
        n_event = r_event;
        if (i_ctl.scan) begin
            if (i_pressed) begin
                if (!r_lock) begin
                    n_count = count_inc;
                    if (count_inc >= i_cfg.long_ticks) begin
                        n_event = EV_LONG;
                        n_lock  = 1'b1;
                    end
                end
            end else begin
                if (r_count >= i_cfg.short_min && r_count < i_cfg.long_ticks) begin
                    n_event = EV_SHORT;
                end
                n_count = '0;
                n_lock  = 1'b0;
            end
        end
        if (i_read_clr) begin
            n_event = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lock  <= 1'b0;
            r_event <= EV_NONE;
        end else if (i_ctl.step) begin
            r_count <= n_count;
            r_lock  <= n_lock;
            r_event <= n_event;
        end
    end

    assign o_event        = r_event;
    assign o_next_pending = (n_event != EV_NONE);

endmodule

// ===== hdl/key_short_long_press_detector.sv =====
// Key short/long press detector: one input beat is either a scan tick carrying the
// active-low key levels or a read that returns and clears one key's latched event.
// Every input beat yields exactly one result beat. Throughput is one beat per cycle
// while m_axis_tready stays high; a beat is captured in the input register and its
// result is written to the result register once that register is free or being
// drained, which raises m_axis_tvalid. The per-key cells update their state in the
// same cycle the beat moves from the input register to the result register.
// Configuration writes are taken on every cycle (o_cfg_ready is always high).
// Depends on kslp_pkg, kslp_cfg and kslp_key_cell.
module key_short_long_press_detector
    import kslp_pkg::*;
#(
    parameter int NUM_KEYS = DEF_NUM_KEYS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [5:0] key_levels, [8:6] key_index, [15:9] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] event_code, [7:2] pending_mask
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    t_cfg cfg;

    logic                      r_in_valid;
    logic                      r_in_req;
    logic [KEY_LEVEL_BITS-1:0] r_in_levels;
    logic [KEY_INDEX_W-1:0]    r_in_index;

    logic                      r_out_valid;
    logic [EVENT_W-1:0]        r_out_code;
    logic [KEY_LEVEL_BITS-1:0] r_out_mask;

    logic                      advance;
    logic                      in_range;
    t_key_ctl                  ctl;
    t_event                    key_event [NUM_KEYS];
    logic [NUM_KEYS-1:0]       next_pending;
    logic [KEY_LEVEL_BITS-1:0] n_mask;
    logic [EVENT_W-1:0]        n_code;

    kslp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Move a beat forward whenever the result slot is free or being drained
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_range      = (32'(r_in_index) < NUM_KEYS);
    assign ctl.step      = advance;
    assign ctl.scan      = !r_in_req;

    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
        logic pressed;
        if (i < KEY_LEVEL_BITS) begin : g_level
            assign pressed = !r_in_levels[i];
        end else begin : g_nolevel
            assign pressed = 1'b0;
        end

        kslp_key_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (ctl),
            .i_cfg          (cfg),
            .i_pressed      (pressed),
            .i_read_clr     (r_in_req && (32'(r_in_index) == i)),
            .o_event        (key_event[i]),
            .o_next_pending (next_pending[i])
        );
    end

    for (genvar i = 0; i < KEY_LEVEL_BITS; i++) begin : g_mask
        if (i < NUM_KEYS) begin : g_present
            assign n_mask[i] = next_pending[i];
        end else begin : g_absent
            assign n_mask[i] = 1'b0;
        end
    end

    always_comb begin
        n_code = EV_NONE;
        if (r_in_req && in_range) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (32'(r_in_index) == i) begin
                    n_code = key_event[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless a new beat lands
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req    <= s_axis_tuser;
            r_in_levels <= s_axis_tdata[KEY_LEVEL_BITS-1:0];
            r_in_index  <= s_axis_tdata[KEY_LEVEL_BITS +: KEY_INDEX_W];
        end
        if (advance) begin
            r_out_code <= n_code;
            r_out_mask <= n_mask;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_mask, r_out_code};

    a_tick_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_req |=> r_out_code == EV_NONE)
        else $error("tick produced a nonzero event code");

    a_absent_key_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_req && !in_range |=> r_out_code == EV_NONE)
        else $error("read of an absent key produced an event");

    a_read_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_req && in_range && (32'(r_in_index) < KEY_LEVEL_BITS)
        |=> r_out_mask[$past(r_in_index)] == 1'b0)
        else $error("pending bit still set after reading its key");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled while the pipeline had room");

endmodule
